[sv/mqrrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrrb_pkg: shared types and constants
// Widths, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package mqrrb_pkg;

  localparam int CORE_COUNT  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int CORE_W      = 3;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int LOAD_W      = 6;
  localparam int ADDR_W      = CORE_W + SLOT_W;
  localparam int ENTRY_W     = 26;

  localparam logic [1:0] CMD_ASSIGN  = 2'd0;
  localparam logic [1:0] CMD_RUN     = 2'd1;
  localparam logic [1:0] CMD_BALANCE = 2'd2;

  localparam logic [2:0] ST_ASSIGNED = 3'd0;
  localparam logic [2:0] ST_REQUEUED = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_IDLE     = 3'd3;
  localparam logic [2:0] ST_MOVED    = 3'd4;
  localparam logic [2:0] ST_NOMOVE   = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  localparam logic [1:0] REG_QUANTUM   = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_CORES     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_MUL1, S_MUL2, S_CMP,
    S_RD, S_RDWAIT, S_EXEC, S_WR, S_OUT
  } seq_state_t;

endpackage

[sv/multi_queue_round_robin_balancer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_round_robin_balancer: per-core task queues with balancing
// Sequenced scheduler over a shared task memory and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: an input beat (valid/ready) carries one command: assign a task to
// the round-robin core, run one time slice on core_sel, or balance the two
// most uneven active cores. Each command returns exactly one output beat
// with the status and the affected task, cores and times.
// The block handles one command at a time and drops in_ready while busy.
// The time a command takes is set by the serial load scan over the cores,
// three passes through the shared multiplier and the registered memory
// read. Full queues and empty cores finish early.
// The result waits in an output register; while the receiver stalls the
// block stays in its output state and accepts no new command.
// Reset (rst, synchronous) empties all queues, clears loads and the
// round-robin pointer, and loads the register defaults (quantum 15,
// threshold 20, two active cores). Task memory needs no clearing.
// Configuration goes through the APB port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module multi_queue_round_robin_balancer
  import mqrrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  task_id,
  input  logic [15:0] work_time,
  input  logic [1:0]  load_weight,
  input  logic [2:0]  core_sel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  out_task_id,
  output logic [2:0]  from_core,
  output logic [2:0]  to_core,
  output logic [7:0]  slice_time,
  output logic [15:0] time_left,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [7:0] slice_limit;
  logic [6:0] threshold_percent;
  logic [3:0] active_cores;
  logic [1:0] reg_idx;
  logic       cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_limit       <= 8'd15;
      threshold_percent <= 7'd20;
      active_cores      <= 4'd2;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_QUANTUM:   slice_limit       <= pwdata[7:0];
        REG_THRESHOLD: threshold_percent <= pwdata[6:0];
        REG_CORES:     active_cores      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUANTUM:   prdata = {24'd0, slice_limit};
      REG_THRESHOLD: prdata = {25'd0, threshold_percent};
      REG_CORES:     prdata = {28'd0, active_cores};
      default:       prdata = 32'd0;
    endcase
  end

  // Effective core count and quantum.
  logic [3:0] ncores;
  logic [7:0] quantum;
  assign ncores  = (active_cores == 4'd0) ? 4'd1 :
                   (active_cores > 4'(CORE_COUNT)) ? 4'(CORE_COUNT) : active_cores;
  assign quantum = (slice_limit == 8'd0) ? 8'd1 : slice_limit;

  // Queue bookkeeping.
  logic [SLOT_W-1:0] qhead  [CORE_COUNT];
  logic [CNT_W-1:0]  qcount [CORE_COUNT];
  logic [LOAD_W-1:0] qload  [CORE_COUNT];
  logic [CORE_W-1:0] rr_pointer;

  // Sequencer registers.
  seq_state_t state, state_next;
  logic [1:0]  c_cmd;
  logic [7:0]  c_id;
  logic [15:0] c_time;
  logic [1:0]  c_ld;
  logic [2:0]  c_sel;
  logic [3:0]  scan_i;
  logic [CORE_W-1:0] maxc, minc;
  logic [LOAD_W-1:0] maxl, minl;
  logic [8:0]  total;
  logic [19:0] prod_a;
  logic [19:0] mul_a;
  logic [6:0]  mul_b;
  logic [26:0] mul_p;
  logic [26:0] prod_r;

  // Result register.
  logic [2:0]  r_status;
  logic [7:0]  r_id;
  logic [2:0]  r_from, r_to;
  logic [7:0]  r_slice;
  logic [15:0] r_left;

  // Memory interface.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  logic [CORE_W-1:0]  src_core, dst_core;

  mqrrb_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared multiplier, one pass per cycle.
  assign mul_p = 27'(mul_a) * 27'(mul_b);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign status      = r_status;
  assign out_task_id = r_id;
  assign from_core   = r_from;
  assign to_core     = r_to;
  assign slice_time  = r_slice;
  assign time_left   = r_left;

  assign mem_raddr = {src_core, qhead[src_core]};
  assign mem_waddr = {dst_core, SLOT_W'(qhead[dst_core] + qcount[dst_core][SLOT_W-1:0])};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and memory control.
  always_comb begin
    state_next = state;
    mul_a      = 20'd0;
    mul_b      = 7'd0;
    mem_we     = 1'b0;
    mem_wdata  = {c_id, c_time, c_ld};
    src_core   = (c_cmd == CMD_RUN) ? c_sel : maxc;
    dst_core   = (c_cmd == CMD_BALANCE) ? minc : c_sel;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (c_cmd)
          CMD_ASSIGN: state_next = (qcount[c_sel] >= CNT_W'(QUEUE_DEPTH)) ? S_OUT : S_WR;
          CMD_RUN:    state_next = (qcount[c_sel] == '0) ? S_OUT : S_RD;
          CMD_BALANCE: state_next = S_SCAN;
          default:    state_next = S_OUT;
        endcase
      end
      S_SCAN: if (scan_i == ncores) state_next = S_MUL1;
      S_MUL1: begin
        mul_a = {14'd0, maxl - minl};
        mul_b = {3'd0, ncores};
        state_next = S_MUL2;
      end
      S_MUL2: begin
        mul_a = prod_a;
        mul_b = 7'd100;
        state_next = S_CMP;
      end
      S_CMP: begin
        mul_a = {11'd0, total};
        mul_b = threshold_percent;
        if (prod_r > mul_p && qcount[maxc] != '0) begin
          state_next = (qcount[minc] >= CNT_W'(QUEUE_DEPTH)) ? S_OUT : S_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_RD:     state_next = S_RDWAIT;
      S_RDWAIT: state_next = S_EXEC;
      S_EXEC: begin
        // A run requeues a task with time left; a balance moves a live task.
        if (c_cmd == CMD_RUN) begin
          state_next = (16'(quantum) < mem_rdata[17:2]) ? S_WR : S_OUT;
        end else begin
          state_next = (mem_rdata[17:2] != 16'd0) ? S_WR : S_OUT;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and queue state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_pointer <= '0;
      for (int i = 0; i < CORE_COUNT; i++) begin
        qhead[i]  <= '0;
        qcount[i] <= '0;
        qload[i]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          c_cmd  <= cmd;
          c_id   <= task_id;
          c_time <= work_time;
          c_ld   <= load_weight;
          c_sel  <= (cmd == CMD_ASSIGN) ?
                    (({1'b0, rr_pointer} < ncores) ? rr_pointer : '0) : core_sel;
          r_status <= ST_IDLE;
          r_id <= '0; r_from <= '0; r_to <= '0; r_slice <= '0; r_left <= '0;
          scan_i <= 4'd1;
          maxc <= '0; minc <= '0;
          maxl <= qload[0]; minl <= qload[0];
          total <= 9'(qload[0]);
        end
        S_DECODE: begin
          case (c_cmd)
            CMD_ASSIGN: begin
              r_id <= c_id; r_from <= c_sel;
              r_status <= ST_FULL;
            end
            CMD_RUN: r_from <= c_sel;
            default: ;
          endcase
        end
        S_SCAN: if (scan_i != ncores) begin
          total <= total + 9'(qload[scan_i[CORE_W-1:0]]);
          if (qload[scan_i[CORE_W-1:0]] > maxl) begin
            maxl <= qload[scan_i[CORE_W-1:0]]; maxc <= scan_i[CORE_W-1:0];
          end
          if (qload[scan_i[CORE_W-1:0]] < minl) begin
            minl <= qload[scan_i[CORE_W-1:0]]; minc <= scan_i[CORE_W-1:0];
          end
          scan_i <= scan_i + 4'd1;
        end
        S_MUL1: prod_a <= mul_p[19:0];
        S_MUL2: prod_r <= mul_p;
        S_CMP: begin
          r_status <= ST_NOMOVE; r_from <= maxc; r_to <= minc;
          if (prod_r > mul_p && qcount[maxc] != '0 &&
              qcount[minc] >= CNT_W'(QUEUE_DEPTH)) r_status <= ST_FULL;
        end
        S_RDWAIT: begin
          // Pop the head of the source queue.
          qhead[src_core]  <= qhead[src_core] + 1'b1;
          qcount[src_core] <= qcount[src_core] - 1'b1;
          qload[src_core]  <= qload[src_core] - LOAD_W'(mem_rdata[1:0]);
        end
        S_EXEC: begin
          c_id <= mem_rdata[25:18];
          c_ld <= mem_rdata[1:0];
          r_id <= mem_rdata[25:18];
          if (c_cmd == CMD_RUN) begin
            if (16'(quantum) < mem_rdata[17:2]) begin
              c_time  <= mem_rdata[17:2] - 16'(quantum);
              r_left  <= mem_rdata[17:2] - 16'(quantum);
              r_slice <= quantum;
              r_status <= ST_REQUEUED;
            end else begin
              c_time  <= '0;
              r_left  <= '0;
              r_slice <= mem_rdata[9:2];
              r_status <= ST_DONE;
            end
          end else begin
            c_time <= mem_rdata[17:2];
            if (mem_rdata[17:2] != 16'd0) begin
              r_left <= mem_rdata[17:2];
              r_status <= ST_MOVED;
            end else begin
              r_status <= ST_DONE;
              r_to <= '0;
            end
          end
        end
        S_WR: begin
          // Push onto the destination queue.
          qcount[dst_core] <= qcount[dst_core] + 1'b1;
          qload[dst_core]  <= qload[dst_core] + LOAD_W'(c_ld);
          if (c_cmd == CMD_ASSIGN) begin
            r_status <= ST_ASSIGNED;
            r_left   <= c_time;
            rr_pointer <= ((4'(c_sel) + 4'd1) == ncores) ? '0 : CORE_W'(c_sel + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/mqrrb_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqrrb_store: task entry memory
// One write port and one registered read port; entries are {id, time, load}.
// ----------------------------------------------------------------------------
module mqrrb_store
  import mqrrb_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [CORE_COUNT*QUEUE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
